// ===== rtl/core/tss_pkg.sv =====
// Shared constants and types for the threshold score sorter.
package tss_pkg;

  localparam int MAX_SCORES_DEF  = 64;
  localparam int SCORE_WIDTH_DEF = 16;
  localparam int IDX_W           = 6;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } tss_state_t;

  typedef struct packed {
    logic ins_en;
    logic shift_en;
  } cell_ctl_t;

endpackage

// ===== rtl/core/tss_cell.sv =====
// One sorting cell: holds one (index, score) pair, inserts or shifts toward the head.
module tss_cell #(
  parameter int SCORE_WIDTH = tss_pkg::SCORE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tss_pkg::cell_ctl_t            ctl,
  input  logic signed [SCORE_WIDTH-1:0] new_score,
  input  logic [tss_pkg::IDX_W-1:0]     new_idx,
  input  logic                          prev_ins,
  input  logic                          prev_valid,
  input  logic signed [SCORE_WIDTH-1:0] prev_score,
  input  logic [tss_pkg::IDX_W-1:0]     prev_idx,
  input  logic                          next_valid,
  input  logic signed [SCORE_WIDTH-1:0] next_score,
  input  logic [tss_pkg::IDX_W-1:0]     next_idx,
  output logic                          valid,
  output logic signed [SCORE_WIDTH-1:0] score,
  output logic [tss_pkg::IDX_W-1:0]     idx,
  output logic                          ins
);
  import tss_pkg::*;

  logic                          valid_r, valid_nxt;
  logic signed [SCORE_WIDTH-1:0] score_r, score_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;

  // new item lands here or further up unless this cell holds a score >= it
  assign ins = !(valid_r && (score_r >= new_score));

  always_comb begin
    valid_nxt = valid_r;
    score_nxt = score_r;
    idx_nxt   = idx_r;
    if (ctl.shift_en) begin
      valid_nxt = next_valid;
      score_nxt = next_score;
      idx_nxt   = next_idx;
    end else if (ctl.ins_en) begin
      valid_nxt = valid_r | (ins & prev_valid);
      if (prev_ins) begin
        score_nxt = prev_score;
        idx_nxt   = prev_idx;
      end else if (ins) begin
        score_nxt = new_score;
        idx_nxt   = new_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    score_r <= score_nxt;
    idx_r   <= idx_nxt;
  end

  assign valid = valid_r;
  assign score = score_r;
  assign idx   = idx_r;

endmodule

// ===== rtl/core/threshold_score_sort.sv =====
// Top level: threshold filter feeding a descending insertion chain, drained on the final item.
// Collect phase: one item per cycle; each that passes the threshold and finds room is inserted
// into the cell chain in the cycle it is accepted. After the item marked final, in_stall rises
// and the chain shifts one result per cycle toward the output register, unless out_stall holds it.
// Input is taken again once the last result of the run is in the output register.
// Synchronous active-low reset clears cell valid bits, counters, flags and threshold (to 0).
module threshold_score_sort #(
  parameter int MAX_SCORES  = tss_pkg::MAX_SCORES_DEF,
  parameter int SCORE_WIDTH = tss_pkg::SCORE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic signed [SCORE_WIDTH-1:0] cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SCORE_WIDTH-1:0] in_score,
  input  logic                          in_final_score,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tss_pkg::IDX_W-1:0]     out_class_index,
  output logic signed [SCORE_WIDTH-1:0] out_kept_score,
  output logic                          out_end_of_list,
  output logic                          out_empty_list,
  output logic                          out_overflowed
);
  import tss_pkg::*;

  localparam int CNT_W = $clog2(MAX_SCORES + 1);

  tss_state_t                    state_r, state_nxt;
  logic signed [SCORE_WIDTH-1:0] threshold_r;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          ovf_r, ovf_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]              out_idx_r;
  logic signed [SCORE_WIDTH-1:0] out_score_r;
  logic                          out_eol_r, out_empty_r, out_ovf_r;

  logic                          in_acc, room, pass, load, last_one;
  cell_ctl_t                     ctl;
  logic [IDX_W-1:0]              new_idx;

  logic                          c_valid [MAX_SCORES];
  logic signed [SCORE_WIDTH-1:0] c_score [MAX_SCORES];
  logic [IDX_W-1:0]              c_idx   [MAX_SCORES];
  logic                          c_ins   [MAX_SCORES];

  assign in_stall = (state_r != ST_COLLECT);
  assign in_acc   = in_valid && !in_stall;
  assign room     = (count_r < CNT_W'(MAX_SCORES));
  assign pass     = (in_score >= threshold_r);
  assign new_idx  = IDX_W'(count_r);
  assign load     = (state_r == ST_DRAIN) && (!out_valid_r || !out_stall);
  assign last_one = !c_valid[0] || !c_valid[1];

  assign ctl.ins_en   = in_acc && room && pass;
  assign ctl.shift_en = load;

  genvar g;
  generate
    for (g = 0; g < MAX_SCORES; g++) begin : g_cell
      logic                          p_ins, p_valid, n_valid;
      logic signed [SCORE_WIDTH-1:0] p_score, n_score;
      logic [IDX_W-1:0]              p_idx, n_idx;

      if (g == 0) begin : g_head
        assign p_ins   = 1'b0;
        assign p_valid = 1'b1;
        assign p_score = in_score;
        assign p_idx   = new_idx;
      end else begin : g_body
        assign p_ins   = c_ins[g-1];
        assign p_valid = c_valid[g-1];
        assign p_score = c_score[g-1];
        assign p_idx   = c_idx[g-1];
      end

      if (g == MAX_SCORES - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_score = in_score;
        assign n_idx   = new_idx;
      end else begin : g_mid
        assign n_valid = c_valid[g+1];
        assign n_score = c_score[g+1];
        assign n_idx   = c_idx[g+1];
      end

      tss_cell #(.SCORE_WIDTH(SCORE_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_score  (in_score),
        .new_idx    (new_idx),
        .prev_ins   (p_ins),
        .prev_valid (p_valid),
        .prev_score (p_score),
        .prev_idx   (p_idx),
        .next_valid (n_valid),
        .next_score (n_score),
        .next_idx   (n_idx),
        .valid      (c_valid[g]),
        .score      (c_score[g]),
        .idx        (c_idx[g]),
        .ins        (c_ins[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (in_acc) begin
      if (room) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_final_score) begin
        state_nxt = ST_DRAIN;
      end
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      if (last_one) begin
        state_nxt = ST_COLLECT;
        count_nxt = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        threshold_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_idx_r   <= c_valid[0] ? c_idx[0] : '0;
      out_score_r <= c_valid[0] ? c_score[0] : '0;
      out_eol_r   <= last_one;
      out_empty_r <= !c_valid[0];
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_class_index = out_idx_r;
  assign out_kept_score  = out_score_r;
  assign out_end_of_list = out_eol_r;
  assign out_empty_list  = out_empty_r;
  assign out_overflowed  = out_ovf_r;

endmodule

// ===== rtl/core/tss_checker.sv =====
// Port-level checks for the threshold score sorter, bound to the top level.
module tss_checker #(
  parameter int SCORE_WIDTH = tss_pkg::SCORE_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_final_score,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tss_pkg::IDX_W-1:0]     out_class_index,
  input logic signed [SCORE_WIDTH-1:0] out_kept_score,
  input logic                          out_end_of_list,
  input logic                          out_empty_list,
  input logic                          out_overflowed
);
  import tss_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_class_index) &&
      $stable(out_kept_score) && $stable(out_end_of_list) &&
      $stable(out_empty_list) && $stable(out_overflowed))
    else $error("stalled item changed");

  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_list |-> out_end_of_list && (out_class_index == '0) &&
      (out_kept_score == '0))
    else $error("empty result malformed");

  a_final_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_score |=> in_stall)
    else $error("input not stalled after final item");

  a_mid_run_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_end_of_list |-> in_stall)
    else $error("input open in the middle of a run");

endmodule

bind threshold_score_sort tss_checker #(.SCORE_WIDTH(SCORE_WIDTH)) u_tss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_final_score  (in_final_score),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_class_index (out_class_index),
  .out_kept_score  (out_kept_score),
  .out_end_of_list (out_end_of_list),
  .out_empty_list  (out_empty_list),
  .out_overflowed  (out_overflowed)
);
